>>> hdl/tuol_pkg.sv
// Shared types and constants for the TAI-UTC offset lookup unit.
// Used by tuol_ctrl, tuol_dpath, tai_utc_offset_lookup_unit and the testbench; depends on nothing.
`default_nettype none

package tuol_pkg;

  localparam int TableDepthDef = 64;

  localparam int ACT_W   = 2;
  localparam int START_W = 46;
  localparam int OFS_W   = 38;
  localparam int REF_W   = 17;
  localparam int SCALE_W = 32;
  localparam int MJD_W   = 41;
  localparam int DIFF_W  = 40;
  localparam int REGN_W  = 2;
  localparam int FRAC_D  = 24;
  localparam int JD_W    = 47;
  localparam int ENTRY_W = START_W + OFS_W + REF_W + SCALE_W;
  localparam int IN_DATA_W  = 176;
  localparam int OUT_DATA_W = 40;

  // 2400000.5 days with 24 fraction bits.
  localparam logic [JD_W-1:0] JdMjdOfs = (JD_W'(2400000) << FRAC_D) + (JD_W'(1) << (FRAC_D - 1));

  localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_APPEND = 2'd1;
  localparam logic [ACT_W-1:0] ACT_QUERY  = 2'd2;

  localparam logic [REGN_W-1:0] REGN_BEFORE = 2'd0;
  localparam logic [REGN_W-1:0] REGN_INSIDE = 2'd1;
  localparam logic [REGN_W-1:0] REGN_AFTER  = 2'd2;
  localparam logic [REGN_W-1:0] REGN_EMPTY  = 2'd3;

  typedef struct packed {
    logic              clear;
    logic              append;
    logic              query_load;
    logic              ptr_last;
    logic              ptr_dec;
    logic              capture;
    logic              set_region;
    logic [REGN_W-1:0] region;
    logic              diff_calc;
    logic              mul_lo;
    logic              mul_hi;
    logic              round;
    logic              out_load;
  } tuol_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic jd_lt;
    logic jd_gt;
    logic out_busy;
  } tuol_stat_t;

endpackage

`default_nettype wire

>>> hdl/tuol_dpath.sv
// Datapath of the TAI-UTC offset lookup: segment table memory, search pointer,
// drift multiplier, rounding, saturation and the result register. Depends on tuol_pkg.
`default_nettype none

module tuol_dpath
  import tuol_pkg::*;
#(
  parameter int TABLE_DEPTH = TableDepthDef
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire tuol_cmd_t          cmd,
  output tuol_stat_t              stat,
  input  wire logic [START_W-1:0] entry_start_jd,
  input  wire logic [OFS_W-1:0]   entry_offset,
  input  wire logic [REF_W-1:0]   entry_ref_mjd,
  input  wire logic [SCALE_W-1:0] entry_scale,
  input  wire logic [MJD_W-1:0]   query_mjd,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [DIFF_W-1:0]       out_difference,
  output logic [REGN_W-1:0]       out_region
);

  localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int LO_W   = 21;
  localparam int HI_W   = MJD_W - LO_W;
  localparam int PP_W   = LO_W + SCALE_W;
  localparam int ACC_W  = MJD_W + SCALE_W;
  localparam int TERM_W = ACC_W - FRAC_D;
  localparam int SUM_W  = TERM_W + 3;
  localparam logic signed [SUM_W-1:0] SatMax = (SUM_W'(1) <<< (DIFF_W - 1)) - SUM_W'(1);
  localparam logic signed [SUM_W-1:0] SatMin = -(SUM_W'(1) <<< (DIFF_W - 1));

  logic [ENTRY_W-1:0] mem [TABLE_DEPTH];
  logic [ENTRY_W-1:0] rd_data_r;
  logic [CNT_W-1:0]   count_r, count_nxt, last_cnt;
  logic [IDX_W-1:0]   ptr_r, ptr_nxt;
  logic               full;

  logic [MJD_W-1:0]   mjd_r;
  logic [JD_W-1:0]    jd_r;
  logic [OFS_W-1:0]   sel_ofs_r;
  logic [REF_W-1:0]   sel_ref_r;
  logic [SCALE_W-1:0] sel_scale_r;
  logic [REGN_W-1:0]  region_r;
  logic [MJD_W-1:0]   mag_r;
  logic               neg_r;
  logic [ACC_W-1:0]   acc_r;
  logic [TERM_W-1:0]  term_r;

  logic [START_W-1:0] rd_start;
  logic [JD_W-1:0]    rd_start_ext;
  logic [MJD_W-1:0]   ref_fx;
  logic [LO_W-1:0]    mul_a;
  logic [PP_W-1:0]    pp;
  logic [ACC_W-1:0]   acc_rnd;
  logic signed [SUM_W-1:0] ofs_ext, term_ext, sum, sat;

  logic               out_valid_r;
  logic [DIFF_W-1:0]  out_diff_r;
  logic [REGN_W-1:0]  out_region_r;

  assign full     = (count_r == CNT_W'(TABLE_DEPTH));
  assign last_cnt = count_r - CNT_W'(1);

  always_comb begin
    count_nxt = count_r;
    if (cmd.clear) begin
      count_nxt = '0;
    end else if (cmd.append && !full) begin
      count_nxt = count_r + CNT_W'(1);
    end
  end

  always_comb begin
    ptr_nxt = ptr_r;
    if (cmd.query_load) begin
      ptr_nxt = '0;
    end else if (cmd.ptr_last) begin
      ptr_nxt = last_cnt[IDX_W-1:0];
    end else if (cmd.ptr_dec && (ptr_r != '0)) begin
      ptr_nxt = ptr_r - IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      ptr_r   <= ptr_nxt;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Table memory: one write port for appends, one registered read port for the search.
  always_ff @(posedge clk) begin
    if (cmd.append && !full) begin
      mem[count_r[IDX_W-1:0]] <= {entry_scale, entry_ref_mjd, entry_offset, entry_start_jd};
    end
    rd_data_r <= mem[ptr_r];
  end

  assign rd_start     = rd_data_r[START_W-1:0];
  assign rd_start_ext = {{(JD_W - START_W){1'b0}}, rd_start};

  assign stat.count_zero = (count_r == '0);
  assign stat.jd_lt      = (jd_r < rd_start_ext);
  assign stat.jd_gt      = (jd_r > rd_start_ext);
  assign stat.out_busy   = out_valid_r && !out_ready;

  assign ref_fx  = {sel_ref_r, {FRAC_D{1'b0}}};
  // The 41-bit magnitude is multiplied in two slices on one 21x32 multiplier.
  assign mul_a   = cmd.mul_hi ? {{(LO_W - HI_W){1'b0}}, mag_r[MJD_W-1:LO_W]} : mag_r[LO_W-1:0];
  assign pp      = PP_W'(mul_a) * PP_W'(sel_scale_r);
  assign acc_rnd = acc_r + (ACC_W'(1) << (FRAC_D - 1));

  assign ofs_ext  = SUM_W'(sel_ofs_r);
  assign term_ext = SUM_W'(term_r);
  assign sum      = neg_r ? (ofs_ext - term_ext) : (ofs_ext + term_ext);

  always_comb begin
    sat = sum;
    if (sum > SatMax) begin
      sat = SatMax;
    end else if (sum < SatMin) begin
      sat = SatMin;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.query_load) begin
      mjd_r <= query_mjd;
      jd_r  <= JD_W'(query_mjd) + JdMjdOfs;
    end
    if (cmd.capture) begin
      sel_ofs_r   <= rd_data_r[START_W +: OFS_W];
      sel_ref_r   <= rd_data_r[START_W + OFS_W +: REF_W];
      sel_scale_r <= rd_data_r[START_W + OFS_W + REF_W +: SCALE_W];
    end
    if (cmd.set_region) begin
      region_r <= cmd.region;
    end
    if (cmd.diff_calc) begin
      if (mjd_r >= ref_fx) begin
        mag_r <= mjd_r - ref_fx;
        neg_r <= 1'b0;
      end else begin
        mag_r <= ref_fx - mjd_r;
        neg_r <= 1'b1;
      end
    end
    if (cmd.mul_lo) begin
      acc_r <= ACC_W'(pp);
    end else if (cmd.mul_hi) begin
      acc_r <= acc_r + (ACC_W'(pp) << LO_W);
    end
    if (cmd.round) begin
      term_r <= acc_rnd[ACC_W-1:FRAC_D];
    end
    if (cmd.out_load) begin
      out_region_r <= region_r;
      if ((region_r == REGN_BEFORE) || (region_r == REGN_EMPTY)) begin
        out_diff_r <= '0;
      end else begin
        out_diff_r <= sat[DIFF_W-1:0];
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_difference = out_diff_r;
  assign out_region     = out_region_r;

endmodule

`default_nettype wire

>>> hdl/tuol_ctrl.sv
// Controller of the TAI-UTC offset lookup: decodes requests, sequences the table
// search and the drift evaluation. Depends on tuol_pkg.
`default_nettype none

module tuol_ctrl
  import tuol_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [ACT_W-1:0] in_action,
  input  wire tuol_stat_t       stat,
  output tuol_cmd_t             cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD0  = 4'd1;
  localparam logic [3:0] S_CHK0 = 4'd2;
  localparam logic [3:0] S_CHKL = 4'd3;
  localparam logic [3:0] S_SCAN = 4'd4;
  localparam logic [3:0] S_DIFF = 4'd5;
  localparam logic [3:0] S_MUL0 = 4'd6;
  localparam logic [3:0] S_MUL1 = 4'd7;
  localparam logic [3:0] S_RND  = 4'd8;
  localparam logic [3:0] S_FIN  = 4'd9;

  logic [3:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Memory data is registered from the pointer register, so each check looks at the
  // entry addressed in the previous state.
  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (in_action)
            ACT_CLEAR:  cmd.clear  = 1'b1;
            ACT_APPEND: cmd.append = 1'b1;
            ACT_QUERY: begin
              cmd.query_load = 1'b1;
              if (stat.count_zero) begin
                cmd.set_region = 1'b1;
                cmd.region     = REGN_EMPTY;
                state_nxt      = S_FIN;
              end else begin
                state_nxt = S_RD0;
              end
            end
            default: ;
          endcase
        end
      end
      S_RD0: begin
        cmd.ptr_last = 1'b1;
        state_nxt    = S_CHK0;
      end
      S_CHK0: begin
        cmd.ptr_dec = 1'b1;
        if (stat.jd_lt) begin
          cmd.set_region = 1'b1;
          cmd.region     = REGN_BEFORE;
          state_nxt      = S_FIN;
        end else begin
          state_nxt = S_CHKL;
        end
      end
      S_CHKL: begin
        if (stat.jd_gt) begin
          cmd.capture    = 1'b1;
          cmd.set_region = 1'b1;
          cmd.region     = REGN_AFTER;
          state_nxt      = S_DIFF;
        end else if (!stat.jd_lt) begin
          cmd.capture    = 1'b1;
          cmd.set_region = 1'b1;
          cmd.region     = REGN_INSIDE;
          state_nxt      = S_DIFF;
        end else begin
          cmd.ptr_dec = 1'b1;
          state_nxt   = S_SCAN;
        end
      end
      S_SCAN: begin
        // The first entry is known not to be after the date, so this ends.
        if (!stat.jd_lt) begin
          cmd.capture    = 1'b1;
          cmd.set_region = 1'b1;
          cmd.region     = REGN_INSIDE;
          state_nxt      = S_DIFF;
        end else begin
          cmd.ptr_dec = 1'b1;
        end
      end
      S_DIFF: begin
        cmd.diff_calc = 1'b1;
        state_nxt     = S_MUL0;
      end
      S_MUL0: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = S_RND;
      end
      S_RND: begin
        cmd.round = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

>>> hdl/tai_utc_offset_lookup_unit.sv
// TAI-UTC offset lookup unit. A clear or append request is handled in the idle state. A
// query on an empty table goes straight to its result, and a query dated before the first
// entry ends after that check. Any other query checks the last entry and, if needed, the
// entries below it. The search walks the table memory from the last entry down through
// its single registered read port. The drift is then multiplied in two slices on one
// 21x32 multiplier. Each result sits in an output register, so the next request is taken
// while it waits to be read. A query stalls in its final state while the previous result
// is still waiting. No clearing pass is needed after reset. Depends on tuol_pkg, tuol_ctrl
// and tuol_dpath.
`default_nettype none

module tai_utc_offset_lookup_unit
  import tuol_pkg::*;
#(
  parameter int TABLE_DEPTH = TableDepthDef
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // entry_start_jd[45:0], entry_offset[83:46], entry_ref_mjd[100:84],
  // entry_scale[132:101], query_mjd[173:133], zero fill above
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // action[1:0]
  input  wire logic [ACT_W-1:0]      in_tuser,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // difference[39:0]
  output logic [OUT_DATA_W-1:0]      out_tdata,
  // region[1:0]
  output logic [REGN_W-1:0]          out_tuser
);

  tuol_cmd_t  cmd;
  tuol_stat_t stat;
  logic [DIFF_W-1:0] difference;

  tuol_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_action (in_tuser),
    .stat      (stat),
    .cmd       (cmd)
  );

  tuol_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .entry_start_jd (in_tdata[START_W-1:0]),
    .entry_offset   (in_tdata[START_W +: OFS_W]),
    .entry_ref_mjd  (in_tdata[START_W + OFS_W +: REF_W]),
    .entry_scale    (in_tdata[START_W + OFS_W + REF_W +: SCALE_W]),
    .query_mjd      (in_tdata[ENTRY_W +: MJD_W]),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_difference (difference),
    .out_region     (out_tuser)
  );

  assign out_tdata = difference;

endmodule

`default_nettype wire

>>> verif/tb_tai_utc_offset_lookup_unit.sv
// Self-checking testbench for tai_utc_offset_lookup_unit: a directed stimulus table, then
// random table fills and queries, checked against a behavioral offset predictor or, for some
// directed rows, a fixed expected result. Depends on tuol_pkg and the RTL under hdl/.
`timescale 1ns / 100ps
`default_nettype none

module tb_tai_utc_offset_lookup_unit;
  import tuol_pkg::*;

  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

  localparam int IDLE_NONE = 0;
  localparam int IDLE_SEND = 1;
  localparam int IDLE_RECV = 2;
  localparam int IDLE_BOTH = 3;

  localparam int RandomRequests = 950;
  localparam int CycleLimit     = 1_000_000;
  localparam int SettleCycles   = TableDepthDef + 20;

  localparam logic signed [63:0] SatHigh = (64'sd1 <<< (DIFF_W - 1)) - 64'sd1;
  localparam logic signed [63:0] SatLow  = -(64'sd1 <<< (DIFF_W - 1));
  localparam logic [DIFF_W-1:0] DiffTop    = {1'b0, {(DIFF_W - 1){1'b1}}};
  localparam logic [DIFF_W-1:0] DiffBottom = {1'b1, {(DIFF_W - 1){1'b0}}};

  typedef struct packed {
    logic [ACT_W-1:0]   act;
    logic [START_W-1:0] start;
    logic [OFS_W-1:0]   ofs;
    logic [REF_W-1:0]   refday;
    logic [SCALE_W-1:0] scale;
    logic [MJD_W-1:0]   mjd;
  } lookup_req_t;

  typedef struct packed {
    logic [DIFF_W-1:0] diff;
    logic [REGN_W-1:0] region;
  } offset_result_t;

  typedef struct packed {
    lookup_req_t    req;
    logic           typed;
    offset_result_t res;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [ACT_W-1:0]      in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [REGN_W-1:0]     out_tuser;

  tai_utc_offset_lookup_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  // Predictor copy of the segment table.
  logic [START_W-1:0] tab_start[TableDepthDef];
  logic [OFS_W-1:0]   tab_ofs[TableDepthDef];
  logic [REF_W-1:0]   tab_refday[TableDepthDef];
  logic [SCALE_W-1:0] tab_scale[TableDepthDef];
  int                 tab_count = 0;

  offset_result_t pending_offsets[$];
  stim_row_t      stim_rows[$];
  offset_result_t got;
  offset_result_t want;
  int             served_requests = 0;
  int             mismatches = 0;
  int             cycle_count = 0;
  int             idle_mode = IDLE_NONE;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic bit hold_off(input int own_mode);
    if (idle_mode == own_mode) return $urandom_range(0, 99) < 86;
    if (idle_mode == IDLE_BOTH) return $urandom_range(0, 99) < 14;
    return 1'b0;
  endfunction

  always @(negedge clk) out_tready = !hold_off(IDLE_RECV);

  // offset + scale * (mjd - reference day), product rounded half away from zero to
  // 32 fraction bits, then clamped to the signed output range.
  function automatic logic [DIFF_W-1:0] drift_offset(input int idx, input logic [MJD_W-1:0] mjd);
    logic [JD_W-1:0]   ref_fx;
    logic [JD_W-1:0]   mag;
    logic              neg;
    logic [79:0]       prod;
    logic signed [63:0] term;
    logic signed [63:0] sum;
    ref_fx = JD_W'(tab_refday[idx]) << FRAC_D;
    neg = JD_W'(mjd) < ref_fx;
    mag = neg ? ref_fx - JD_W'(mjd) : JD_W'(mjd) - ref_fx;
    prod = 80'(mag) * 80'(tab_scale[idx]) + (80'(1) << (FRAC_D - 1));
    term = $signed(64'(prod >> FRAC_D));
    if (neg) term = -term;
    sum = $signed({26'd0, tab_ofs[idx]}) + term;
    if (sum > SatHigh) sum = SatHigh;
    if (sum < SatLow) sum = SatLow;
    return sum[DIFF_W-1:0];
  endfunction

  task automatic predict_request(input lookup_req_t r, input logic typed,
                                 input offset_result_t fixed);
    offset_result_t   res;
    logic [JD_W-1:0]  jd;
    int               hit;
    int               i;
    case (r.act)
      ACT_CLEAR: begin
        tab_count = 0;
        served_requests++;
      end
      ACT_APPEND: begin
        if (tab_count < TableDepthDef) begin
          tab_start[tab_count]  = r.start;
          tab_ofs[tab_count]    = r.ofs;
          tab_refday[tab_count] = r.refday;
          tab_scale[tab_count]  = r.scale;
          tab_count++;
          served_requests++;
        end
      end
      ACT_QUERY: begin
        jd = JD_W'(r.mjd) + JdMjdOfs;
        res.diff = '0;
        if (tab_count == 0) begin
          res.region = REGN_EMPTY;
        end else if (jd < JD_W'(tab_start[0])) begin
          res.region = REGN_BEFORE;
        end else if (jd > JD_W'(tab_start[tab_count - 1])) begin
          res.region = REGN_AFTER;
          res.diff = drift_offset(tab_count - 1, r.mjd);
        end else begin
          // Highest index whose start is not after the date; also defined when unordered.
          hit = 0;
          for (i = 0; i < tab_count; i++)
            if (JD_W'(tab_start[i]) <= jd) hit = i;
          res.region = REGN_INSIDE;
          res.diff = drift_offset(hit, r.mjd);
        end
        if (typed) res = fixed;
        pending_offsets.push_back(res);
        served_requests++;
      end
      default: ;
    endcase
  endtask

  task automatic send_request(input lookup_req_t r, input logic typed,
                              input offset_result_t fixed);
    @(negedge clk);
    while (hold_off(IDLE_SEND)) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tuser  = r.act;
    in_tdata  = {2'b00, r.mjd, r.scale, r.refday, r.ofs, r.start};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    predict_request(r, typed, fixed);
  endtask

  task automatic wait_results_done();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_offsets.size() != 0) @(posedge clk);
  endtask

  task automatic note_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", what);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got.diff = out_tdata;
      got.region = out_tuser;
      if (pending_offsets.size() == 0) begin
        note_mismatch($sformatf("unexpected result diff=%0d region=%0d",
                                $signed(got.diff), got.region));
      end else begin
        want = pending_offsets.pop_front();
        if (got.diff !== want.diff)
          note_mismatch($sformatf("difference expected %0d got %0d",
                                  $signed(want.diff), $signed(got.diff)));
        if (got.region !== want.region)
          note_mismatch($sformatf("region expected %0d got %0d", want.region, got.region));
      end
    end
  end

  function automatic stim_row_t row(input logic [ACT_W-1:0] act, input logic [START_W-1:0] start,
                                    input logic [OFS_W-1:0] ofs, input logic [REF_W-1:0] refday,
                                    input logic [SCALE_W-1:0] scale, input logic [MJD_W-1:0] mjd,
                                    input logic typed = 1'b0, input logic [DIFF_W-1:0] diff = '0,
                                    input logic [REGN_W-1:0] region = REGN_EMPTY);
    stim_row_t s;
    s.req = '{act, start, ofs, refday, scale, mjd};
    s.typed = typed;
    s.res = '{diff, region};
    return s;
  endfunction

  function automatic logic [START_W-1:0] jd_of_day(input int day);
    return START_W'(JdMjdOfs) + (START_W'(day) << FRAC_D);
  endfunction

  initial begin
    lookup_req_t        r;
    offset_result_t     none;
    logic [START_W-1:0] seq_starts[$];
    logic [START_W-1:0] cur;
    logic [63:0]        below;
    int                 seq_no;
    int                 n;
    int                 k;
    int                 j;
    int                 pick;

    none = '0;
    stim_rows.push_back(row(ACT_QUERY, '0, '0, '0, '0, '0, 1'b1, '0, REGN_EMPTY));
    stim_rows.push_back(row(ACT_QUERY, '1, '1, '1, '1, '1, 1'b1, '0, REGN_EMPTY));
    stim_rows.push_back(row(ACT_APPEND, '1, '1, '1, '1, '1));
    stim_rows.push_back(row(ACT_CLEAR, '1, '1, '1, '1, '1));
    stim_rows.push_back(row(ACT_UNUSED, '1, '1, '1, '1, '1));
    stim_rows.push_back(row(ACT_QUERY, '0, '0, '0, '0, MJD_W'(50000) << FRAC_D, 1'b1, '0,
                            REGN_EMPTY));
    // A small leap-second style table, flat but for the last segment.
    stim_rows.push_back(row(ACT_APPEND, jd_of_day(41317), OFS_W'(10) << 32, 17'd41317, '0, '0));
    stim_rows.push_back(row(ACT_APPEND, jd_of_day(41499), OFS_W'(11) << 32, '0, '0, '0));
    stim_rows.push_back(row(ACT_APPEND, jd_of_day(57754), OFS_W'(37) << 32, 17'd57754,
                            32'h0012_3456, '0));
    stim_rows.push_back(row(ACT_QUERY, '0, '0, '0, '0, '0, 1'b1, '0, REGN_BEFORE));
    stim_rows.push_back(row(ACT_QUERY, '0, '0, '0, '0, MJD_W'(41317) << FRAC_D));
    stim_rows.push_back(row(ACT_QUERY, '0, '0, '0, '0, (MJD_W'(50000) << FRAC_D) + 41'h7fffff));
    stim_rows.push_back(row(ACT_QUERY, '0, '0, '0, '0, MJD_W'(57754) << FRAC_D));
    stim_rows.push_back(row(ACT_QUERY, '0, '0, '0, '0, '1));
    // Drift large enough to clamp at the top of the range.
    stim_rows.push_back(row(ACT_CLEAR, '0, '0, '0, '0, '0));
    stim_rows.push_back(row(ACT_APPEND, '0, '1, '0, '1, '0));
    stim_rows.push_back(row(ACT_QUERY, '0, '0, '0, '0, '1, 1'b1, DiffTop, REGN_AFTER));
    // Negative drift from a far reference day clamps at the bottom.
    stim_rows.push_back(row(ACT_CLEAR, '0, '0, '0, '0, '0));
    stim_rows.push_back(row(ACT_APPEND, '0, '0, '1, '1, '0));
    stim_rows.push_back(row(ACT_QUERY, '0, '0, '0, '0, '0, 1'b1, DiffBottom, REGN_AFTER));
    // A single entry at the largest start lies beyond any query date.
    stim_rows.push_back(row(ACT_CLEAR, '0, '0, '0, '0, '0));
    stim_rows.push_back(row(ACT_APPEND, '1, '1, '1, '1, '0));
    stim_rows.push_back(row(ACT_QUERY, '0, '0, '0, '0, '1, 1'b1, '0, REGN_BEFORE));

    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    foreach (stim_rows[i]) send_request(stim_rows[i].req, stim_rows[i].typed, stim_rows[i].res);
    wait_results_done();

    served_requests = 0;
    seq_no = 0;
    while (served_requests < RandomRequests) begin
      // Idle pattern changes every few runs; the sender drains the block at each change.
      idle_mode = (seq_no / 5) % 4;
      if (seq_no % 5 == 0) wait_results_done();
      if ($urandom_range(0, 99) < 80) begin
        r = '0;
        r.act = ACT_CLEAR;
        r.mjd = MJD_W'({$urandom, $urandom});
        send_request(r, 1'b0, none);
        pick = $urandom_range(0, 99);
        if (seq_no == 0 || pick >= 92) n = $urandom_range(TableDepthDef, TableDepthDef + 6);
        else if (pick >= 72) n = $urandom_range(11, 40);
        else n = $urandom_range(1, 10);
        seq_starts.delete();
        cur = START_W'(JdMjdOfs) + START_W'(40'({$urandom, $urandom}));
        for (k = 0; k < n; k++) begin
          r.act    = ACT_APPEND;
          r.start  = cur;
          r.ofs    = OFS_W'({$urandom, $urandom});
          r.refday = REF_W'($urandom);
          r.scale  = $urandom_range(0, 1) ? $urandom : ($urandom >> 20);
          r.mjd    = MJD_W'({$urandom, $urandom});
          send_request(r, 1'b0, none);
          seq_starts.push_back(cur);
          cur = cur + START_W'(34'({$urandom, $urandom})) + 1'b1;
        end
        if (n > TableDepthDef) n = TableDepthDef;
        for (j = $urandom_range(3, 10); j > 0; j--) begin
          r = '0;
          r.act    = ACT_QUERY;
          r.start  = START_W'({$urandom, $urandom});
          r.ofs    = OFS_W'({$urandom, $urandom});
          r.refday = REF_W'($urandom);
          r.scale  = $urandom;
          k = $urandom_range(0, n - 1);
          case ($urandom_range(0, 3))
            0: r.mjd = MJD_W'(seq_starts[k] - START_W'(JdMjdOfs));
            1: r.mjd = MJD_W'(seq_starts[k] - START_W'(JdMjdOfs))
                       + MJD_W'($urandom_range(0, 1 << 25)) - (MJD_W'(1) << FRAC_D);
            2: begin
              below = 64'(seq_starts[0] - START_W'(JdMjdOfs));
              r.mjd = (below == 0) ? '0 : MJD_W'(64'({$urandom, $urandom}) % below);
            end
            default: r.mjd = MJD_W'({$urandom, $urandom});
          endcase
          send_request(r, 1'b0, none);
        end
      end else begin
        // Noise: random codes and full-range fields, tables left unordered.
        for (j = $urandom_range(4, 16); j > 0; j--) begin
          pick = $urandom_range(0, 9);
          r.act    = (pick == 0) ? ACT_CLEAR : (pick == 1) ? ACT_UNUSED :
                     (pick < 6) ? ACT_APPEND : ACT_QUERY;
          r.start  = START_W'({$urandom, $urandom});
          r.ofs    = OFS_W'({$urandom, $urandom});
          r.refday = REF_W'($urandom);
          r.scale  = $urandom;
          r.mjd    = MJD_W'({$urandom, $urandom});
          send_request(r, 1'b0, none);
        end
      end
      if ($urandom_range(0, 7) == 0) wait_results_done();
      seq_no++;
    end

    wait_results_done();
    repeat (SettleCycles) @(posedge clk);
    if (pending_offsets.size() != 0)
      note_mismatch($sformatf("%0d results never arrived", pending_offsets.size()));
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
hdl/tuol_pkg.sv
hdl/tuol_dpath.sv
hdl/tuol_ctrl.sv
hdl/tai_utc_offset_lookup_unit.sv
verif/tb_tai_utc_offset_lookup_unit.sv
